>>> hdl/cbyp_pkg.sv
// shared constants and types for the camera basis block
`timescale 1ns / 1ps

package cbyp_pkg;

  localparam logic [30:0] Q30_ONE         = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
  localparam logic [29:0] PITCH_LIMIT_RST = 30'd1061811359;

  localparam int unsigned SIN_STEPS = 5;
  localparam int unsigned COS_STEPS = 6;
  localparam int unsigned SIN_K [SIN_STEPS] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_K [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_e;

  typedef struct packed {
    logic        vld;
    logic [31:0] x2;
    logic [30:0] t;
  } link_t;

endpackage

>>> hdl/cbyp_cell.sv
// one horner step cell: t_out = 1 - x2 * t / K, clamped at zero
`timescale 1ns / 1ps

module cbyp_cell
  import cbyp_pkg::*;
#(
  parameter int unsigned K = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  link_t link_i,
  output link_t link_o
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
  localparam logic [7:0]  KC    = 8'(K);

  logic        v1_q, v2_q, v3_q;
  logic [31:0] x2a_q, x2b_q, x2c_q;
  logic [61:0] prod_q;
  logic [31:0] quo_q;
  logic [63:0] est_q;
  logic [30:0] t_q;

  logic [62:0] prod_full;
  logic [31:0] quo;
  logic [31:0] qe;
  logic [39:0] back;
  logic [39:0] remv;
  logic [32:0] dv;
  logic [30:0] t_d;

  assign prod_full = 63'(link_i.x2) * 63'(link_i.t);
  assign quo       = prod_q[61:30];
  assign qe        = est_q[63:32];
  assign back      = 40'(qe) * 40'(KC);
  assign remv      = 40'(quo_q) - back;
  assign dv        = 33'(qe) + 33'(remv >= 40'(KC));
  assign t_d       = (dv > 33'(Q30_ONE)) ? 31'd0 : 31'(33'(Q30_ONE) - dv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= link_i.vld;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[61:0];
    x2a_q  <= link_i.x2;
    quo_q  <= quo;
    est_q  <= 64'(quo) * 64'(RECIP);
    x2b_q  <= x2a_q;
    t_q    <= t_d;
    x2c_q  <= x2b_q;
  end

  assign link_o.vld = v3_q;
  assign link_o.x2  = x2c_q;
  assign link_o.t   = t_q;

endmodule

>>> hdl/cbyp_trig.sv
// sine and cosine of a binary angle through chains of horner cells
`timescale 1ns / 1ps

module cbyp_trig
  import cbyp_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [ANGLE_BITS-1:0]   angle_i,
  output logic                    done_o,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);

  localparam int unsigned RW = ANGLE_BITS - 2;

  logic              va_q, vb_q, done_q;
  logic [30:0]       x_q;
  quad_e             quad_q;
  logic [31:0]       x2_q;
  logic [30:0]       s_q;
  logic signed [31:0] sin_q, cos_q;

  logic [RW+30:0]    xprod;
  logic [61:0]       x2prod;
  logic [61:0]       sprod;
  logic [31:0]       sv;
  logic signed [31:0] s_sg, c_sg;

  link_t sin_link [SIN_STEPS+1];
  link_t cos_link [COS_STEPS+1];

  assign xprod  = (RW+31)'(angle_i[RW-1:0]) * (RW+31)'(HALF_PI_Q30);
  assign x2prod = 62'(x_q) * 62'(x_q);

  assign sin_link[0] = '{vld: vb_q, x2: x2_q, t: Q30_ONE};
  assign cos_link[0] = '{vld: vb_q, x2: x2_q, t: Q30_ONE};

  for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
    cbyp_cell #(.K(SIN_K[i])) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .link_i (sin_link[i]),
      .link_o (sin_link[i+1])
    );
  end

  for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
    cbyp_cell #(.K(COS_K[i])) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .link_i (cos_link[i]),
      .link_o (cos_link[i+1])
    );
  end

  assign sprod = 62'(x_q) * 62'(sin_link[SIN_STEPS].t);
  assign sv    = 32'(sprod >> 30);
  assign s_sg  = 32'(s_q);
  assign c_sg  = 32'(cos_link[COS_STEPS].t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      va_q   <= start_i;
      vb_q   <= va_q;
      done_q <= cos_link[COS_STEPS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= 31'(xprod >> RW);
      quad_q <= quad_e'(angle_i[ANGLE_BITS-1:ANGLE_BITS-2]);
    end
    if (va_q) begin
      x2_q <= 32'(x2prod >> 30);
    end
    if (sin_link[SIN_STEPS].vld) begin
      s_q <= (sv > 32'(Q30_ONE)) ? Q30_ONE : 31'(sv);
    end
    if (cos_link[COS_STEPS].vld) begin
      case (quad_q)
        QUAD_0: begin sin_q <= s_sg;  cos_q <= c_sg;  end
        QUAD_1: begin sin_q <= c_sg;  cos_q <= -s_sg; end
        QUAD_2: begin sin_q <= -s_sg; cos_q <= -c_sg; end
        default: begin sin_q <= -c_sg; cos_q <= s_sg; end
      endcase
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

>>> hdl/camera_basis_from_yaw_pitch.sv
// top level: yaw and pitch accumulation and camera basis vectors
//
// input channel in_valid_i / in_ready_o carries yaw_step_i and pitch_step_i,
// binary angle increments with 2^ANGLE_BITS units per turn; yaw wraps and
// pitch is clamped to plus or minus the pitch limit (at most a quarter turn
// minus one unit)
// config channel cfg_valid_i / cfg_ready_o writes the pitch limit; it is
// always ready and is meant to be written while the block is idle
// output channel out_valid_o / out_ready_i carries front, left (x, z) and
// up vectors in signed Q1.FRAC_BITS
// one item at a time: sine and cosine of yaw, then of pitch, each go through
// a row of horner cells (six cells of three stages on the cosine side), and
// the next item is taken only once the result of the last one has gone into
// the output register
// the result sits in an output register; a new item is accepted while it
// waits, and a stalled receiver only holds the block at the final rounding
// step until the register frees
// reset clears yaw and pitch to zero and loads the default limit of 89 degrees
`timescale 1ns / 1ps

module camera_basis_from_yaw_pitch
  import cbyp_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [29:0]                cfg_pitch_limit_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [31:0]         yaw_step_i,
  input  logic signed [31:0]         pitch_step_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [FRAC_BITS+1:0] front_x_o,
  output logic signed [FRAC_BITS+1:0] front_y_o,
  output logic signed [FRAC_BITS+1:0] front_z_o,
  output logic signed [FRAC_BITS+1:0] left_x_o,
  output logic signed [FRAC_BITS+1:0] left_z_o,
  output logic signed [FRAC_BITS+1:0] up_x_o,
  output logic signed [FRAC_BITS+1:0] up_y_o,
  output logic signed [FRAC_BITS+1:0] up_z_o
);

  localparam int unsigned OW  = FRAC_BITS + 2;
  localparam int unsigned AB  = ANGLE_BITS;
  localparam int unsigned SH1 = 30 - FRAC_BITS;
  localparam int unsigned SH2 = 60 - FRAC_BITS;
  localparam logic [29:0] QMAX = 30'((64'd1 << (AB - 2)) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_YAW,
    S_YWAIT,
    S_PIT,
    S_PWAIT,
    S_MUL,
    S_RND
  } state_e;

  function automatic logic [OW-1:0] round_q(input logic signed [63:0] v,
                                            input int unsigned sh);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] half;
    logic [63:0] res;
    neg  = v[63];
    mag  = neg ? 64'(-v) : 64'(v);
    half = (sh > 0) ? (64'd1 << (sh - 1)) : 64'd0;
    mag  = (mag + half) >> sh;
    res  = neg ? (64'd0 - mag) : mag;
    return res[OW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic [AB-1:0]     yaw_q, yaw_d;
  logic [AB-1:0]     pitch_q, pitch_d;
  logic [29:0]       limit_q;
  logic [OW-1:0]     fx_q, fy_q, fz_q, lx_q, lz_q, ux_q, uy_q, uz_q;
  logic              load_out;

  logic signed [31:0] sy_q, cy_q, sp_q, cp_q;
  logic signed [63:0] p_cc_q, p_sc_q, p_cs_q, p_ss_q;

  logic              trig_start;
  logic [AB-1:0]     trig_angle;
  logic              trig_done;
  logic signed [31:0] trig_sin, trig_cos;

  logic              in_xfer;
  logic [29:0]       lim;
  logic signed [33:0] psum, plim;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;

  assign lim  = (limit_q > QMAX) ? QMAX : limit_q;
  assign plim = 34'(lim);
  assign psum = 34'($signed(pitch_q)) + 34'($signed(pitch_step_i[AB-1:0]));
  assign yaw_d = yaw_q + yaw_step_i[AB-1:0];

  always_comb begin
    if (psum > plim) begin
      pitch_d = plim[AB-1:0];
    end else if (psum < -plim) begin
      pitch_d = AB'(-plim);
    end else begin
      pitch_d = psum[AB-1:0];
    end
  end

  assign trig_start = (state_q == S_YAW) || (state_q == S_PIT);
  assign trig_angle = (state_q == S_YAW) ? yaw_q : pitch_q;
  assign load_out   = (state_q == S_RND) && (!out_valid_q || out_ready_i);

  cbyp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .angle_i (trig_angle),
    .done_o  (trig_done),
    .sin_o   (trig_sin),
    .cos_o   (trig_cos)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_YAW;
      S_YAW:   state_d = S_YWAIT;
      S_YWAIT: if (trig_done) state_d = S_PIT;
      S_PIT:   state_d = S_PWAIT;
      S_PWAIT: if (trig_done) state_d = S_MUL;
      S_MUL:   state_d = S_RND;
      S_RND: begin
        if (load_out) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      yaw_q       <= '0;
      pitch_q     <= '0;
      limit_q     <= PITCH_LIMIT_RST;
      fx_q <= '0; fy_q <= '0; fz_q <= '0; lx_q <= '0;
      lz_q <= '0; ux_q <= '0; uy_q <= '0; uz_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_pitch_limit_i;
      end
      if (in_xfer) begin
        yaw_q   <= yaw_d;
        pitch_q <= pitch_d;
      end
      if (load_out) begin
        fx_q <= round_q(p_cc_q, SH2);
        fy_q <= round_q(64'(sp_q), SH1);
        fz_q <= round_q(p_sc_q, SH2);
        lx_q <= round_q(64'(sy_q), SH1);
        lz_q <= round_q(-64'(cy_q), SH1);
        ux_q <= round_q(-p_cs_q, SH2);
        uy_q <= round_q(64'(cp_q), SH1);
        uz_q <= round_q(-p_ss_q, SH2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_YWAIT && trig_done) begin
      sy_q <= trig_sin;
      cy_q <= trig_cos;
    end
    if (state_q == S_PWAIT && trig_done) begin
      sp_q <= trig_sin;
      cp_q <= trig_cos;
    end
    if (state_q == S_MUL) begin
      p_cc_q <= 64'(cy_q) * 64'(cp_q);
      p_sc_q <= 64'(sy_q) * 64'(cp_q);
      p_cs_q <= 64'(cy_q) * 64'(sp_q);
      p_ss_q <= 64'(sy_q) * 64'(sp_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign front_x_o   = fx_q;
  assign front_y_o   = fy_q;
  assign front_z_o   = fz_q;
  assign left_x_o    = lx_q;
  assign left_z_o    = lz_q;
  assign up_x_o      = ux_q;
  assign up_y_o      = uy_q;
  assign up_z_o      = uz_q;

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_done |-> (state_q == S_YWAIT || state_q == S_PWAIT))
    else $error("trig done outside wait state");

  a_pitch_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> ($signed(pitch_q) <= $signed({1'b0, QMAX})
                 && $signed(pitch_q) >= -$signed({1'b0, QMAX})))
    else $error("pitch outside quarter turn");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RND && out_valid_q && !out_ready_i) |=> state_q == S_RND)
    else $error("result overwritten while stalled");

  a_no_start_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_start |=> !trig_start)
    else $error("back to back trig start");
`endif

endmodule
